### src/ascii85_group_decoder_core_assert.svh
// Assertion macros for the ascii85 group decoder.
// Each macro takes a label, an antecedent, a consequent and a message.
// They expand to nothing in synthesis.
`ifndef ASCII85_GROUP_DECODER_CORE_ASSERT_SVH
`define ASCII85_GROUP_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define A85GD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define A85GD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define A85GD_ASSERT_NOW(name, ante, cons, msg)

`define A85GD_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

### src/a85gd_pkg.sv
package a85gd_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DATA       = 2'd0,
        ST_INVALID    = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_CLEAN      = 2'd3
    } status_t;

    localparam logic [7:0] DIGIT_LO     = 8'd33;
    localparam logic [7:0] DIGIT_HI     = 8'd117;
    localparam logic [2:0] GROUP_DIGITS = 3'd5;
    localparam int         QUEUE_DEPTH  = 4;
    localparam int         BYTES_PER_WORD = 4;

    // One queued result: a decoded word (four beats) or a status (one beat)
    typedef struct packed {
        status_t     status;
        logic [31:0] word;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Weight of a digit by its position within the group
    function automatic logic [25:0] pow85(input logic [2:0] pos);
        logic [25:0] w;
        case (pos)
            3'd0:    w = 26'd1;
            3'd1:    w = 26'd85;
            3'd2:    w = 26'd7225;
            3'd3:    w = 26'd614125;
            3'd4:    w = 26'd52200625;
            default: w = 26'd1;
        endcase
        return w;
    endfunction

endpackage

### src/ascii85_group_decoder_core.sv
// ASCII85 group decoder. Takes one character beat per cycle (or an end
// marker beat) and returns decoded bytes and status beats. Whitespace is
// skipped; characters '!' through 'u' are base-85 digits, five to a group,
// most significant first, and each full group yields four data beats (most
// significant byte first, group_last on the fourth). Any other character
// yields one invalid-character beat and makes the error sticky: later
// characters are dropped until the end marker. The end marker yields one
// beat whose status reports the earlier error, an incomplete group, or a
// clean end, then returns the decoder to its reset state. There is no 'z'
// shortcut and no short final group. Input beats are taken at one per cycle;
// each beat is decoded in the cycle it is accepted and its results are
// written into a result queue of QUEUE_DEPTH entries (a group's word or one
// status per entry), drained at one output beat per cycle while out_stall is
// low. The input stalls only while that queue is full, so while the output
// is not stalled a steady stream runs at one input beat per cycle.

`include "ascii85_group_decoder_core_assert.svh"

module ascii85_group_decoder_core #(
    parameter int QUEUE_DEPTH = a85gd_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] symbol,
    input  logic       end_marker,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       group_last
);

    // Decoder state
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  digits_left_reg, digits_left_next;
    logic        error_seen_reg, error_seen_next;

    logic             accept;
    logic             queue_full;
    logic             is_blank;
    logic             is_digit;
    logic [6:0]       digit;
    logic [2:0]       pos;
    logic [31:0]      product;
    logic [31:0]      acc_sum;
    a85gd_pkg::push_t push;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        is_blank = symbol inside {[8'd9:8'd13], 8'd32};
        is_digit = symbol inside {[a85gd_pkg::DIGIT_LO:a85gd_pkg::DIGIT_HI]};
    end

    // One constant-weight multiply and one add per digit; the sum wraps mod 2^32
    assign digit   = 7'(symbol - a85gd_pkg::DIGIT_LO);
    assign pos     = 3'(digits_left_reg - 3'd1);
    assign product = 32'(34'(digit) * 34'(a85gd_pkg::pow85(pos)));
    assign acc_sum = acc_reg + product;

    always_comb
    begin
        acc_next          = acc_reg;
        digits_left_next  = digits_left_reg;
        error_seen_next   = error_seen_reg;
        push.valid        = 1'b0;
        push.entry.status = a85gd_pkg::ST_DATA;
        push.entry.word   = 32'd0;
        if (accept)
        begin
            if (end_marker)
            begin
                // Report how the stream ended, then return to reset state
                push.valid = 1'b1;
                if (error_seen_reg)
                begin
                    push.entry.status = a85gd_pkg::ST_INVALID;
                end
                else if (digits_left_reg != a85gd_pkg::GROUP_DIGITS)
                begin
                    push.entry.status = a85gd_pkg::ST_INCOMPLETE;
                end
                else
                begin
                    push.entry.status = a85gd_pkg::ST_CLEAN;
                end
                acc_next         = 32'd0;
                digits_left_next = a85gd_pkg::GROUP_DIGITS;
                error_seen_next  = 1'b0;
            end
            else if (error_seen_reg || is_blank)
            begin
                // Drop the beat
            end
            else if (!is_digit)
            begin
                // Keep the partial group, flag the error once
                push.valid        = 1'b1;
                push.entry.status = a85gd_pkg::ST_INVALID;
                error_seen_next   = 1'b1;
            end
            else if (digits_left_reg == 3'd1)
            begin
                // Fifth digit: hand the whole word to the result queue
                push.valid        = 1'b1;
                push.entry.status = a85gd_pkg::ST_DATA;
                push.entry.word   = acc_sum;
                acc_next          = 32'd0;
                digits_left_next  = a85gd_pkg::GROUP_DIGITS;
            end
            else
            begin
                acc_next         = acc_sum;
                digits_left_next = pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= 32'd0;
            digits_left_reg <= a85gd_pkg::GROUP_DIGITS;
            error_seen_reg  <= 1'b0;
        end
        else
        begin
            acc_reg         <= acc_next;
            digits_left_reg <= digits_left_next;
            error_seen_reg  <= error_seen_next;
        end
    end

    a85gd_result_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (queue_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .status     (status),
        .group_last (group_last)
    );

    // Digit count stays within one group
    `A85GD_ASSERT_NOW(a_digits_range, 1'b1, digits_left_reg >= 3'd1 && digits_left_reg <= a85gd_pkg::GROUP_DIGITS, "digit count out of range")

    // End marker restores the reset state
    `A85GD_ASSERT_NEXT(a_end_resets, accept && end_marker, acc_reg == 32'd0 && digits_left_reg == a85gd_pkg::GROUP_DIGITS && !error_seen_reg, "end marker did not reset state")

    // Error stays set until an end marker
    `A85GD_ASSERT_NEXT(a_error_sticky, error_seen_reg && !(accept && end_marker), error_seen_reg, "error flag dropped early")

    // A partial group never coexists with a cleared count
    `A85GD_ASSERT_NOW(a_idle_acc_zero, digits_left_reg == a85gd_pkg::GROUP_DIGITS, acc_reg == 32'd0, "accumulator not clear at group start")

endmodule

### src/a85gd_result_queue.sv
module a85gd_result_queue #(
    parameter int QUEUE_DEPTH = a85gd_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  a85gd_pkg::push_t    push,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic [1:0]          status,
    output logic                group_last
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int BEAT_W  = $clog2(a85gd_pkg::BYTES_PER_WORD);
    localparam logic [PTR_W-1:0]  PTR_MAX  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [BEAT_W-1:0] BEAT_MAX = BEAT_W'(a85gd_pkg::BYTES_PER_WORD - 1);

    a85gd_pkg::entry_t entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;

    a85gd_pkg::entry_t head_entry;
    logic              beat_take;
    logic              entry_done;
    logic              is_data;
    logic [7:0]        byte_sel;

    assign head_entry = entry_reg[head_reg];
    assign is_data    = (head_entry.status == a85gd_pkg::ST_DATA);
    assign out_valid  = (count_reg != '0);
    assign full       = (count_reg == CNT_FULL);
    assign beat_take  = out_valid && !out_stall;
    assign group_last = !is_data || (beat_reg == BEAT_MAX);
    assign entry_done = beat_take && group_last;

    // Most significant byte first
    always_comb
    begin
        byte_sel = 8'(head_entry.word >> ({3'd0, BEAT_MAX - beat_reg} * 5'd8));
    end

    assign out_byte = is_data ? byte_sel : 8'd0;
    assign status   = head_entry.status;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        beat_next  = beat_reg;
        if (beat_take)
        begin
            beat_next = entry_done ? '0 : BEAT_W'(beat_reg + 1'b1);
        end
        if (entry_done)
        begin
            head_next = (head_reg == PTR_MAX) ? '0 : PTR_W'(head_reg + 1'b1);
        end
        if (push.valid)
        begin
            tail_next = (tail_reg == PTR_MAX) ? '0 : PTR_W'(tail_reg + 1'b1);
        end
        case ({push.valid, entry_done})
            2'b10:   count_next = CNT_W'(count_reg + 1'b1);
            2'b01:   count_next = CNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            beat_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[tail_reg] <= push.entry;
        end
    end

endmodule
